>>> rtl/qsm3_pkg.sv
// shared types, sizes and datapath operation codes for the median-of-three quicksort block
// no dependencies; imported by qsm3_ctrl, qsm3_dp and the top level
`default_nettype none

package qsm3_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int STACK_DEPTH  = 8;
    localparam int DATA_W       = 32;

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    // signed index: holds one below zero and one past the last entry
    localparam int IDX_W  = ADDR_W + 2;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW = $clog2(STACK_DEPTH);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [IDX_W-1:0]  idx_t;

    typedef struct packed {
        data_t value;
        logic  last;
    } item_t;

    typedef struct packed {
        data_t sorted_value;
        logic  final_res;
        logic  overflow;
    } res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } range_t;

    localparam int OP_W = 5;

    localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
    localparam logic [OP_W-1:0] OP_POP     = 5'd2;
    localparam logic [OP_W-1:0] OP_MED0    = 5'd3;
    localparam logic [OP_W-1:0] OP_MED1    = 5'd4;
    localparam logic [OP_W-1:0] OP_MED2    = 5'd5;
    localparam logic [OP_W-1:0] OP_MED3    = 5'd6;
    localparam logic [OP_W-1:0] OP_CS01    = 5'd7;
    localparam logic [OP_W-1:0] OP_CS02    = 5'd8;
    localparam logic [OP_W-1:0] OP_CS12    = 5'd9;
    localparam logic [OP_W-1:0] OP_PIV1    = 5'd10;
    localparam logic [OP_W-1:0] OP_PIV2    = 5'd11;
    localparam logic [OP_W-1:0] OP_A_RD    = 5'd12;
    localparam logic [OP_W-1:0] OP_A_STEP  = 5'd13;
    localparam logic [OP_W-1:0] OP_A_STOP  = 5'd14;
    localparam logic [OP_W-1:0] OP_B_RD    = 5'd15;
    localparam logic [OP_W-1:0] OP_B_STEP  = 5'd16;
    localparam logic [OP_W-1:0] OP_B_STOP  = 5'd17;
    localparam logic [OP_W-1:0] OP_SW1     = 5'd18;
    localparam logic [OP_W-1:0] OP_SW2     = 5'd19;
    localparam logic [OP_W-1:0] OP_FIN0    = 5'd20;
    localparam logic [OP_W-1:0] OP_FIN1    = 5'd21;
    localparam logic [OP_W-1:0] OP_FIN2    = 5'd22;
    localparam logic [OP_W-1:0] OP_SPLIT   = 5'd23;
    localparam logic [OP_W-1:0] OP_I_RD    = 5'd24;
    localparam logic [OP_W-1:0] OP_I_V     = 5'd25;
    localparam logic [OP_W-1:0] OP_K_RD    = 5'd26;
    localparam logic [OP_W-1:0] OP_K_SHIFT = 5'd27;
    localparam logic [OP_W-1:0] OP_I_PUT   = 5'd28;
    localparam logic [OP_W-1:0] OP_E_RD    = 5'd29;
    localparam logic [OP_W-1:0] OP_E_LD    = 5'd30;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic sp_zero;
        logic a_le_hi;
        logic a1_le_hi;
        logic b_ge_lo1;
        logic b1_ge_lo1;
        logic a_le_b;
        logic piv_ge_rd;
        logic piv_le_rd;
        logic ins_needed;
        logic i_le_ih;
        logic k_gt_il;
        logic rd_gt_v;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/qsm3_ctrl.sv
// sequencer for load, partition, insertion fallback and emit phases
// depends on qsm3_pkg; drives qsm3_dp through cmd_t and reads sts_t
`default_nettype none

module qsm3_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    input  wire                   item_last,
    output logic                  item_ready,
    input  wire qsm3_pkg::sts_t   sts,
    output qsm3_pkg::cmd_t        cmd
);
    import qsm3_pkg::*;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_TOP   = 5'd1;
    localparam logic [4:0] S_MED0  = 5'd2;
    localparam logic [4:0] S_MED1  = 5'd3;
    localparam logic [4:0] S_MED2  = 5'd4;
    localparam logic [4:0] S_MED3  = 5'd5;
    localparam logic [4:0] S_CS01  = 5'd6;
    localparam logic [4:0] S_CS02  = 5'd7;
    localparam logic [4:0] S_CS12  = 5'd8;
    localparam logic [4:0] S_PIV1  = 5'd9;
    localparam logic [4:0] S_PIV2  = 5'd10;
    localparam logic [4:0] S_LOOP  = 5'd11;
    localparam logic [4:0] S_SA    = 5'd12;
    localparam logic [4:0] S_SAW   = 5'd13;
    localparam logic [4:0] S_SB    = 5'd14;
    localparam logic [4:0] S_SBW   = 5'd15;
    localparam logic [4:0] S_XCHK  = 5'd16;
    localparam logic [4:0] S_SW1   = 5'd17;
    localparam logic [4:0] S_SW2   = 5'd18;
    localparam logic [4:0] S_FIN0  = 5'd19;
    localparam logic [4:0] S_FIN1  = 5'd20;
    localparam logic [4:0] S_FIN2  = 5'd21;
    localparam logic [4:0] S_SPLIT = 5'd22;
    localparam logic [4:0] S_ITOP  = 5'd23;
    localparam logic [4:0] S_IV    = 5'd24;
    localparam logic [4:0] S_KRD   = 5'd25;
    localparam logic [4:0] S_KCMP  = 5'd26;
    localparam logic [4:0] S_IPUT  = 5'd27;
    localparam logic [4:0] S_ERD   = 5'd28;
    localparam logic [4:0] S_ELD   = 5'd29;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       accept;

    assign item_ready = (state_reg == S_LOAD);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                    if (item_last)
                    begin
                        state_next = S_TOP;
                    end
                end
            end
            S_TOP:
            begin
                if (sts.lo_lt_hi)
                begin
                    state_next = S_MED0;
                end
                else if (sts.sp_zero)
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    cmd.op = OP_POP;
                end
            end
            S_MED0:
            begin
                cmd.op     = OP_MED0;
                state_next = S_MED1;
            end
            S_MED1:
            begin
                cmd.op     = OP_MED1;
                state_next = S_MED2;
            end
            S_MED2:
            begin
                cmd.op     = OP_MED2;
                state_next = S_MED3;
            end
            S_MED3:
            begin
                cmd.op     = OP_MED3;
                state_next = S_CS01;
            end
            S_CS01:
            begin
                cmd.op     = OP_CS01;
                state_next = S_CS02;
            end
            S_CS02:
            begin
                cmd.op     = OP_CS02;
                state_next = S_CS12;
            end
            S_CS12:
            begin
                cmd.op     = OP_CS12;
                state_next = S_PIV1;
            end
            S_PIV1:
            begin
                cmd.op     = OP_PIV1;
                state_next = S_PIV2;
            end
            S_PIV2:
            begin
                cmd.op     = OP_PIV2;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                state_next = sts.a_le_b ? S_SA : S_FIN0;
            end
            S_SA:
            begin
                if (sts.a_le_hi)
                begin
                    cmd.op     = OP_A_RD;
                    state_next = S_SAW;
                end
                else
                begin
                    state_next = S_SB;
                end
            end
            S_SAW:
            begin
                if (sts.piv_ge_rd)
                begin
                    cmd.op     = OP_A_STEP;
                    state_next = sts.a1_le_hi ? S_SAW : S_SB;
                end
                else
                begin
                    cmd.op     = OP_A_STOP;
                    state_next = S_SB;
                end
            end
            S_SB:
            begin
                if (sts.b_ge_lo1)
                begin
                    cmd.op     = OP_B_RD;
                    state_next = S_SBW;
                end
                else
                begin
                    state_next = S_XCHK;
                end
            end
            S_SBW:
            begin
                if (sts.piv_le_rd)
                begin
                    cmd.op     = OP_B_STEP;
                    state_next = sts.b1_ge_lo1 ? S_SBW : S_XCHK;
                end
                else
                begin
                    cmd.op     = OP_B_STOP;
                    state_next = S_XCHK;
                end
            end
            S_XCHK:
            begin
                state_next = sts.a_le_b ? S_SW1 : S_FIN0;
            end
            S_SW1:
            begin
                cmd.op     = OP_SW1;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                cmd.op     = OP_SW2;
                state_next = S_LOOP;
            end
            S_FIN0:
            begin
                cmd.op     = OP_FIN0;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                cmd.op     = OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op     = OP_FIN2;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op     = OP_SPLIT;
                state_next = sts.ins_needed ? S_ITOP : S_TOP;
            end
            S_ITOP:
            begin
                if (sts.i_le_ih)
                begin
                    cmd.op     = OP_I_RD;
                    state_next = S_IV;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end
            S_IV:
            begin
                cmd.op     = OP_I_V;
                state_next = S_KRD;
            end
            S_KRD:
            begin
                if (sts.k_gt_il)
                begin
                    cmd.op     = OP_K_RD;
                    state_next = S_KCMP;
                end
                else
                begin
                    state_next = S_IPUT;
                end
            end
            S_KCMP:
            begin
                if (sts.rd_gt_v)
                begin
                    cmd.op     = OP_K_SHIFT;
                    state_next = S_KRD;
                end
                else
                begin
                    state_next = S_IPUT;
                end
            end
            S_IPUT:
            begin
                cmd.op     = OP_I_PUT;
                state_next = S_ITOP;
            end
            S_ERD:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_E_RD;
                    state_next = S_ELD;
                end
            end
            S_ELD:
            begin
                cmd.op     = OP_E_LD;
                state_next = sts.emit_last ? S_LOAD : S_ERD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/qsm3_dp.sv
// datapath: element store, range stack, scan and insertion registers, result register
// depends on qsm3_pkg; executes one cmd_t operation per cycle from qsm3_ctrl
`default_nettype none

module qsm3_dp (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire qsm3_pkg::data_t  item_value,
    input  wire qsm3_pkg::cmd_t   cmd,
    output qsm3_pkg::sts_t        sts,
    output qsm3_pkg::res_t        res,
    output logic                  res_valid,
    input  wire                   res_ready
);
    import qsm3_pkg::*;

    // element store, single write and single registered read port
    data_t             mem [MAX_ELEMENTS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    data_t             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    data_t             rdata_reg;

    range_t            stk_reg [STACK_DEPTH];
    logic              stk_we;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ADDR_W-1:0] e_reg, e_next;
    logic              out_valid_reg, out_valid_next;

    idx_t  lo_reg, lo_next, hi_reg, hi_next;
    idx_t  a_reg, a_next, b_reg, b_next;
    idx_t  il_reg, il_next, ih_reg, ih_next;
    idx_t  i_reg, i_next, k_reg, k_next;
    data_t piv_reg, piv_next, vlo_reg, vlo_next;
    data_t va_reg, va_next, vb_reg, vb_next, v_reg, v_next;
    idx_t  c_idx_reg [3];
    idx_t  c_idx_next [3];
    data_t c_val_reg [3];
    data_t c_val_next [3];
    res_t  out_reg, out_next;

    logic               full;
    logic [CNT_W-1:0]   count_inc;
    logic signed [IDX_W:0] mid_sum;
    idx_t               mid;
    logic [SP_W-1:0]    sp_m1;
    idx_t               blo, bhi, slo, shi;
    logic               big_nt, stk_full, push;
    logic               emit_last;

    assign full      = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign count_inc = full ? count_reg : count_reg + CNT_W'(1);
    assign mid_sum   = (IDX_W+1)'(lo_reg) + (IDX_W+1)'(hi_reg);
    assign mid       = mid_sum[IDX_W:1];
    assign sp_m1     = sp_reg - SP_W'(1);
    assign emit_last = (CNT_W'(e_reg) == count_reg - CNT_W'(1));

    // partition point is b; the larger side goes on the stack, or is insertion-sorted when the stack is full
    always_comb
    begin
        if ((b_reg - lo_reg) > (hi_reg - b_reg))
        begin
            blo = lo_reg;
            bhi = b_reg - idx_t'(1);
            slo = b_reg + idx_t'(1);
            shi = hi_reg;
        end
        else
        begin
            blo = b_reg + idx_t'(1);
            bhi = hi_reg;
            slo = lo_reg;
            shi = b_reg - idx_t'(1);
        end
        big_nt   = (blo < bhi);
        stk_full = (sp_reg == SP_W'(STACK_DEPTH));
        push     = big_nt && !stk_full;
    end

    always_comb
    begin
        sts.lo_lt_hi   = (lo_reg < hi_reg);
        sts.sp_zero    = (sp_reg == '0);
        sts.a_le_hi    = (a_reg <= hi_reg);
        sts.a1_le_hi   = ((a_reg + idx_t'(1)) <= hi_reg);
        sts.b_ge_lo1   = (b_reg >= (lo_reg + idx_t'(1)));
        sts.b1_ge_lo1  = ((b_reg - idx_t'(1)) >= (lo_reg + idx_t'(1)));
        sts.a_le_b     = (a_reg <= b_reg);
        sts.piv_ge_rd  = (piv_reg >= rdata_reg);
        sts.piv_le_rd  = (piv_reg <= rdata_reg);
        sts.ins_needed = big_nt && stk_full;
        sts.i_le_ih    = (i_reg <= ih_reg);
        sts.k_gt_il    = (k_reg > il_reg);
        sts.rd_gt_v    = (rdata_reg > v_reg);
        sts.emit_last  = emit_last;
        sts.out_free   = !out_valid_reg || res_ready;
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sp_next        = sp_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        il_next        = il_reg;
        ih_next        = ih_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        piv_next       = piv_reg;
        vlo_next       = vlo_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        v_next         = v_reg;
        c_idx_next     = c_idx_reg;
        c_val_next     = c_val_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        stk_we         = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd.op)
            OP_LOAD:
            begin
                if (!full)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = count_reg[ADDR_W-1:0];
                    mem_wdata = item_value;
                end
                count_next = count_inc;
                ovf_next   = ovf_reg | full;
                lo_next    = '0;
                hi_next    = idx_t'(count_inc) - idx_t'(1);
                sp_next    = '0;
            end
            OP_POP:
            begin
                sp_next = sp_m1;
                lo_next = idx_t'(stk_reg[sp_m1[STK_AW-1:0]].lo);
                hi_next = idx_t'(stk_reg[sp_m1[STK_AW-1:0]].hi);
            end
            OP_MED0:
            begin
                mem_re    = 1'b1;
                mem_raddr = lo_reg[ADDR_W-1:0];
            end
            OP_MED1:
            begin
                mem_re        = 1'b1;
                mem_raddr     = mid[ADDR_W-1:0];
                c_idx_next[0] = lo_reg;
                c_val_next[0] = rdata_reg;
                vlo_next      = rdata_reg;
            end
            OP_MED2:
            begin
                mem_re        = 1'b1;
                mem_raddr     = hi_reg[ADDR_W-1:0];
                c_idx_next[1] = mid;
                c_val_next[1] = rdata_reg;
            end
            OP_MED3:
            begin
                c_idx_next[2] = hi_reg;
                c_val_next[2] = rdata_reg;
            end
            OP_CS01:
            begin
                if (c_val_reg[0] >= c_val_reg[1])
                begin
                    c_idx_next[0] = c_idx_reg[1];
                    c_val_next[0] = c_val_reg[1];
                    c_idx_next[1] = c_idx_reg[0];
                    c_val_next[1] = c_val_reg[0];
                end
            end
            OP_CS02:
            begin
                if (c_val_reg[0] >= c_val_reg[2])
                begin
                    c_idx_next[0] = c_idx_reg[2];
                    c_val_next[0] = c_val_reg[2];
                    c_idx_next[2] = c_idx_reg[0];
                    c_val_next[2] = c_val_reg[0];
                end
            end
            OP_CS12:
            begin
                if (c_val_reg[1] >= c_val_reg[2])
                begin
                    c_idx_next[1] = c_idx_reg[2];
                    c_val_next[1] = c_val_reg[2];
                    c_idx_next[2] = c_idx_reg[1];
                    c_val_next[2] = c_val_reg[1];
                end
            end
            OP_PIV1:
            begin
                // move the pivot to the front: first half of the exchange
                piv_next  = c_val_reg[1];
                mem_we    = 1'b1;
                mem_waddr = c_idx_reg[1][ADDR_W-1:0];
                mem_wdata = vlo_reg;
            end
            OP_PIV2:
            begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[ADDR_W-1:0];
                mem_wdata = piv_reg;
                a_next    = lo_reg + idx_t'(1);
                b_next    = hi_reg;
            end
            OP_A_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = a_reg[ADDR_W-1:0];
            end
            OP_A_STEP:
            begin
                a_next    = a_reg + idx_t'(1);
                mem_re    = 1'b1;
                mem_raddr = a_next[ADDR_W-1:0];
            end
            OP_A_STOP:
            begin
                va_next = rdata_reg;
            end
            OP_B_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = b_reg[ADDR_W-1:0];
            end
            OP_B_STEP:
            begin
                b_next    = b_reg - idx_t'(1);
                mem_re    = 1'b1;
                mem_raddr = b_next[ADDR_W-1:0];
            end
            OP_B_STOP:
            begin
                vb_next = rdata_reg;
            end
            OP_SW1:
            begin
                mem_we    = 1'b1;
                mem_waddr = a_reg[ADDR_W-1:0];
                mem_wdata = vb_reg;
            end
            OP_SW2:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg[ADDR_W-1:0];
                mem_wdata = va_reg;
            end
            OP_FIN0:
            begin
                mem_re    = 1'b1;
                mem_raddr = b_reg[ADDR_W-1:0];
            end
            OP_FIN1:
            begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[ADDR_W-1:0];
                mem_wdata = rdata_reg;
            end
            OP_FIN2:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg[ADDR_W-1:0];
                mem_wdata = piv_reg;
            end
            OP_SPLIT:
            begin
                if (push)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + SP_W'(1);
                end
                il_next = blo;
                ih_next = bhi;
                i_next  = blo + idx_t'(1);
                lo_next = slo;
                hi_next = shi;
            end
            OP_I_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg[ADDR_W-1:0];
            end
            OP_I_V:
            begin
                v_next = rdata_reg;
                k_next = i_reg;
            end
            OP_K_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(k_reg - idx_t'(1));
            end
            OP_K_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[ADDR_W-1:0];
                mem_wdata = rdata_reg;
                k_next    = k_reg - idx_t'(1);
            end
            OP_I_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[ADDR_W-1:0];
                mem_wdata = v_reg;
                i_next    = i_reg + idx_t'(1);
            end
            OP_E_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = e_reg;
            end
            OP_E_LD:
            begin
                out_next.sorted_value = rdata_reg;
                out_next.final_res    = emit_last;
                out_next.overflow     = ovf_reg;
                out_valid_next        = 1'b1;
                e_next                = e_reg + ADDR_W'(1);
                if (emit_last)
                begin
                    // run done, ready for the next one
                    e_next     = '0;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
        if (stk_we)
        begin
            stk_reg[sp_reg[STK_AW-1:0]] <= '{lo: blo[ADDR_W-1:0], hi: bhi[ADDR_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sp_reg        <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            sp_reg        <= sp_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        il_reg    <= il_next;
        ih_reg    <= ih_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        piv_reg   <= piv_next;
        vlo_reg   <= vlo_next;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        v_reg     <= v_next;
        c_idx_reg <= c_idx_next;
        c_val_reg <= c_val_next;
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("range stack pointer past stack depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count past store size");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_E_LD) |-> !out_valid_reg)
        else $error("result register loaded while still holding a result");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_E_LD && emit_last) |=> (count_reg == '0 && !ovf_reg && sp_reg == '0))
        else $error("run state not cleared after final result");

endmodule

`default_nettype wire

>>> rtl/quicksort_median_of_three_top.sv
// top level of the median-of-three quicksort block: controller plus datapath
// depends on qsm3_pkg, qsm3_ctrl and qsm3_dp
//
//   channel  dir  handshake                 payload
//   item     in   item_valid / item_ready   item.value, item.last
//   res      out  res_valid / res_ready     res.sorted_value, res.final_res, res.overflow
//
// load takes one cycle per transfer; item_ready is high only while loading
// sorting uses one read or one write of the element store per cycle: a scan examines one
// element per cycle after a start read, and a pop takes the next range off the stack;
// runs of equal values make the scans quadratic
// emit reads each result from the store, then loads it into the output register; res_ready low stalls it
// the next run starts loading while the final result still waits in the output register
// reset clears control only; no clearing pass is needed
`default_nettype none

module quicksort_median_of_three_top (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_ready,
    input  wire qsm3_pkg::item_t  item,
    output logic                  res_valid,
    input  wire                   res_ready,
    output qsm3_pkg::res_t        res
);
    import qsm3_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qsm3_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    qsm3_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_value (item.value),
        .cmd        (cmd),
        .sts        (sts),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready)
    );

endmodule

`default_nettype wire
